// ===== src/scaled_glyph_blitter_defines.svh =====
// ----------------------------------------------------------------------------
// scaled_glyph_blitter assertion macros
// assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_BLITTER_DEFINES_SVH
`define SCALED_GLYPH_BLITTER_DEFINES_SVH
`ifndef SYNTHESIS
`define SGB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sgb assertion failed");
`define SGB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sgb assertion failed");
`else
`define SGB_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SGB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg
// shared types and constants of the scaled glyph blitter
// ----------------------------------------------------------------------------
`default_nettype none
package sgb_pkg;
    localparam int FB_COLS       = 800;
    localparam int FB_ROWS       = 480;
    localparam int BITMAP_BYTES  = 512;
    localparam int PIXEL_BITS    = 16;
    localparam int BYTE_AW       = $clog2(BITMAP_BYTES);
    localparam int DIV_STEPS     = 15;
    localparam int ADV_MAX       = 16383;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  byte_index;
        logic [7:0]  byte_value;
        logic [7:0]  char_code;
        logic        glyph_present;
        logic [7:0]  glyph_advance;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [6:0]  point_size;
        logic [15:0] ink;
    } in_item_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [18:0] pixel_address;
        logic [15:0] pixel_color;
        logic [13:0] scaled_advance;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        MUL_ADV,
        MUL_PX,
        MUL_PY
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        logic     div_load;
        mul_sel_t mul_sel;
        logic     div_step;
        logic     addr_calc;
        logic     bit_calc;
        logic     mem_rd;
        logic     emit;
    } sgb_cmd_t;

    typedef struct packed {
        logic scan_active;
        logic div_done;
        logic out_free;
    } sgb_status_t;
endpackage
`default_nettype wire

// ===== src/sgb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgb_ctrl
// sequencer: steps the datapath through multiply, divide, lookup and output
// ----------------------------------------------------------------------------
`default_nettype none
module sgb_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic [1:0]           s_kind,
    output logic                      s_ready,
    input  wire sgb_pkg::sgb_status_t status,
    output sgb_pkg::sgb_cmd_t         cmd
);
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV_MUL,
        ST_ADV_DIV,
        ST_PX_MUL,
        ST_PX_DIV,
        ST_PY_MUL,
        ST_PY_DIV,
        ST_BIT,
        ST_RD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        cmd.mul_sel = sgb_pkg::MUL_ADV;
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_kind == sgb_pkg::KIND_START) begin
                        state_next = ST_ADV_MUL;
                    end else if (s_kind == sgb_pkg::KIND_STEP && status.scan_active) begin
                        state_next = ST_PX_MUL;
                    end
                end
            end
            ST_ADV_MUL: begin
                cmd.div_load = 1'b1;
                cmd.mul_sel  = sgb_pkg::MUL_ADV;
                state_next   = ST_ADV_DIV;
            end
            ST_ADV_DIV: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_PX_MUL: begin
                cmd.div_load = 1'b1;
                cmd.mul_sel  = sgb_pkg::MUL_PX;
                state_next   = ST_PX_DIV;
            end
            ST_PX_DIV: begin
                if (status.div_done) begin
                    state_next = ST_PY_MUL;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_PY_MUL: begin
                cmd.div_load  = 1'b1;
                cmd.mul_sel   = sgb_pkg::MUL_PY;
                cmd.addr_calc = 1'b1;
                state_next    = ST_PY_DIV;
            end
            ST_PY_DIV: begin
                if (status.div_done) begin
                    state_next = ST_BIT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_BIT: begin
                cmd.bit_calc = 1'b1;
                state_next   = ST_RD;
            end
            ST_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/sgb_datapath.sv =====
// ----------------------------------------------------------------------------
// sgb_datapath
// held glyph state, shared multiply and restoring divider, bitmap store,
// output register
// ----------------------------------------------------------------------------
`default_nettype none
module sgb_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sgb_pkg::sgb_cmd_t   cmd,
    input  wire sgb_pkg::in_item_t   s_data,
    input  wire logic [6:0]          font_w,
    input  wire logic [6:0]          font_h,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output sgb_pkg::out_item_t       m_data,
    output sgb_pkg::sgb_status_t     status
);
    logic [7:0]  mem [sgb_pkg::BITMAP_BYTES];
    logic [7:0]  mem_q_reg;

    logic        scan_active_reg;
    logic [6:0]  scan_col_reg, scan_row_reg;
    logic [11:0] held_ox_reg, held_oy_reg;
    logic [6:0]  held_size_reg;
    logic [15:0] held_ink_reg;
    logic [7:0]  held_adv_reg;
    logic        is_step_reg;
    logic        adv_zero_reg;

    logic [14:0] dvd_reg;
    logic [7:0]  rem_reg;
    logic [6:0]  dvs_reg;
    logic [3:0]  cnt_reg;
    logic [6:0]  px_reg;
    logic [14:0] bitno_reg;
    logic [18:0] addr_reg;
    logic        inwin_reg;

    logic        m_valid_reg;
    sgb_pkg::out_item_t m_data_reg, item_next;

    logic [6:0]  mul_a, mul_b, div_by;
    logic [13:0] mul_p;
    logic [8:0]  rem_sh;
    logic [7:0]  rem_next;
    logic        q_bit;
    logic [12:0] dx, dy;
    logic [24:0] addr_prod;
    logic [13:0] bit_prod;
    logic [7:0]  col_inc, row_inc;
    logic        col_end, row_end, fin;
    logic        hit;
    logic [13:0] adv_sat;

    // operand and divisor select for the multiplier shared by the two coordinates
    always_comb begin
        case (cmd.mul_sel)
            sgb_pkg::MUL_ADV: begin
                mul_a  = held_adv_reg[6:0];
                mul_b  = held_size_reg;
                div_by = font_w;
            end
            sgb_pkg::MUL_PX: begin
                mul_a  = scan_col_reg;
                mul_b  = font_w;
                div_by = held_size_reg;
            end
            sgb_pkg::MUL_PY: begin
                mul_a  = scan_row_reg;
                mul_b  = font_h;
                div_by = held_size_reg;
            end
            default: begin
                mul_a  = '0;
                mul_b  = '0;
                div_by = held_size_reg;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // advance uses all 8 bits of the glyph advance
    logic [14:0] div_in;
    always_comb begin
        if (cmd.mul_sel == sgb_pkg::MUL_ADV) begin
            div_in = held_adv_reg * held_size_reg;
        end else begin
            div_in = {1'b0, mul_p};
        end
    end

    // one restoring step per cycle
    always_comb begin
        rem_sh = {rem_reg, dvd_reg[14]};
        q_bit  = (rem_sh >= {2'b00, dvs_reg});
        rem_next = q_bit ? 8'(rem_sh - {2'b00, dvs_reg}) : rem_sh[7:0];
    end

    always_comb begin
        dx        = {1'b0, held_ox_reg} + 13'(scan_col_reg);
        dy        = {1'b0, held_oy_reg} + 13'(held_size_reg) - 13'(scan_row_reg);
        addr_prod = dx * 12'(sgb_pkg::FB_ROWS);
        bit_prod  = px_reg * font_h;
        col_inc   = {1'b0, scan_col_reg} + 8'd1;
        row_inc   = {1'b0, scan_row_reg} + 8'd1;
        col_end   = (col_inc >= {1'b0, held_size_reg});
        row_end   = (row_inc >= {1'b0, held_size_reg});
        fin       = col_end && row_end;
        hit       = inwin_reg && (bitno_reg[14:3] < 12'(sgb_pkg::BITMAP_BYTES))
                    && mem_q_reg[bitno_reg[2:0]];
        adv_sat   = (dvd_reg > 15'(sgb_pkg::ADV_MAX)) ? 14'(sgb_pkg::ADV_MAX)
                                                      : dvd_reg[13:0];
    end

    always_comb begin
        item_next = '0;
        if (is_step_reg) begin
            item_next.pixel_valid = hit;
            if (hit) begin
                item_next.pixel_address = addr_reg;
                item_next.pixel_color   = held_ink_reg[sgb_pkg::PIXEL_BITS-1:0];
            end
            item_next.last = fin;
        end else begin
            item_next.scaled_advance = adv_zero_reg ? '0 : adv_sat;
            item_next.last           = !scan_active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_data.kind == sgb_pkg::KIND_LOAD) begin
            mem[s_data.byte_index[sgb_pkg::BYTE_AW-1:0]] <= s_data.byte_value;
        end
        if (cmd.mem_rd) begin
            mem_q_reg <= mem[bitno_reg[sgb_pkg::BYTE_AW+2:3]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg <= 1'b0;
            scan_col_reg    <= '0;
            scan_row_reg    <= '0;
            held_ox_reg     <= '0;
            held_oy_reg     <= '0;
            held_size_reg   <= '0;
            held_ink_reg    <= '0;
            is_step_reg     <= 1'b0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.accept) begin
                is_step_reg <= (s_data.kind == sgb_pkg::KIND_STEP);
                if (s_data.kind == sgb_pkg::KIND_START) begin
                    held_ox_reg     <= s_data.origin_x;
                    held_oy_reg     <= s_data.origin_y;
                    held_size_reg   <= s_data.point_size;
                    held_ink_reg    <= s_data.ink;
                    scan_col_reg    <= '0;
                    scan_row_reg    <= '0;
                    scan_active_reg <= !s_data.char_code[7] && s_data.glyph_present
                                       && (s_data.point_size != '0);
                end
            end
            if (cmd.div_load) begin
                cnt_reg <= 4'(sgb_pkg::DIV_STEPS);
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg - 4'd1;
            end
            if (cmd.emit && is_step_reg) begin
                if (fin) begin
                    scan_active_reg <= 1'b0;
                    scan_col_reg    <= '0;
                    scan_row_reg    <= '0;
                end else if (row_end) begin
                    scan_row_reg <= '0;
                    scan_col_reg <= col_inc[6:0];
                end else begin
                    scan_row_reg <= row_inc[6:0];
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            held_adv_reg <= s_data.glyph_advance;
            adv_zero_reg <= s_data.char_code[7] || (font_w == '0);
        end
        if (cmd.div_load) begin
            dvd_reg <= div_in;
            rem_reg <= '0;
            dvs_reg <= div_by;
            if (cmd.mul_sel == sgb_pkg::MUL_PY) begin
                px_reg <= dvd_reg[6:0];
            end
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[13:0], q_bit};
            rem_reg <= rem_next;
        end
        if (cmd.addr_calc) begin
            // column-major index: row plus column times the frame height
            addr_reg  <= addr_prod[18:0] + {6'd0, dy};
            inwin_reg <= (dx < 13'(sgb_pkg::FB_COLS))
                         && (dy < 13'(sgb_pkg::FB_ROWS));
        end
        if (cmd.bit_calc) begin
            bitno_reg <= {1'b0, bit_prod} + 15'(dvd_reg[6:0]);
        end
        if (cmd.emit) begin
            m_data_reg <= item_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_data             = m_data_reg;
    assign status.scan_active = scan_active_reg;
    assign status.div_done    = (cnt_reg == '0);
    assign status.out_free    = !m_valid_reg || m_ready;
endmodule
`default_nettype wire

// ===== src/scaled_glyph_blitter.sv =====
// ----------------------------------------------------------------------------
// scaled_glyph_blitter
// nearest-neighbor scaled bitmap glyph renderer for a column-major frame buffer
// ----------------------------------------------------------------------------
// One item is taken at a time. A load item, and a step item while no scan is
// active, gives no result. A start item, and a step item during a scan, reaches
// the output register before the next item is accepted. The advance and each
// of the two source coordinates go through one shared restoring divider that
// retires one quotient bit per cycle (15 bits), plus a multiply, a bitmap
// store read and the output register. A finished result waits in the output
// register while the next item is accepted; if it is still waiting when the
// next result is ready, the block stalls until it is taken.
`default_nettype none
`include "scaled_glyph_blitter_defines.svh"
module scaled_glyph_blitter (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire sgb_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output sgb_pkg::out_item_t      m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [6:0] font_w_reg, font_h_reg;
    sgb_pkg::sgb_cmd_t    cmd;
    sgb_pkg::sgb_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_w_reg <= 7'd8;
            font_h_reg <= 7'd16;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                sgb_pkg::REG_WIDTH:  font_w_reg <= pwdata[6:0];
                sgb_pkg::REG_HEIGHT: font_h_reg <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    assign prdata = (paddr[2] == sgb_pkg::REG_HEIGHT) ? {25'd0, font_h_reg}
                                                      : {25'd0, font_w_reg};
    assign pready = 1'b1;

    sgb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sgb_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .font_w  (font_w_reg),
        .font_h  (font_h_reg),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .status  (status)
    );

    `SGB_ASSERT_SAME(a_pix_in_window, aclk, aresetn, m_valid && m_data.pixel_valid, m_data.pixel_address < 19'd384000)
    `SGB_ASSERT_SAME(a_miss_is_blank, aclk, aresetn, m_valid && !m_data.pixel_valid, m_data.pixel_address == '0 && m_data.pixel_color == '0)
    `SGB_ASSERT_SAME(a_adv_no_pixel, aclk, aresetn, m_valid && m_data.scaled_advance != '0, !m_data.pixel_valid)
    `SGB_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule
`default_nettype wire
